// ===== hw/rtl/bsbid_pkg.sv =====
// bsbid_pkg: shared types and fixed field widths for the set-bit index decoder
// used by bsbid_ctrl, bsbid_datapath and bitmap_set_bit_index_decoder
// no dependencies
`default_nettype none

package bsbid_pkg;

   localparam int WORD_FIELD_BITS  = 64;
   localparam int INDEX_FIELD_BITS = 32;
   localparam int SLOT_BITS        = 32;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture a new item
      logic emit;   // decode lowest set bit into the output register
   } bsbid_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic in_nonzero;   // incoming word has at least one decoded bit set
      logic last_bit;     // stored word holds at most one set bit
   } bsbid_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_set_bit_index_decoder.sv =====
// bitmap_set_bit_index_decoder: top level of the set-bit index decoder
// depends on bsbid_pkg, bsbid_ctrl and bsbid_datapath
//
// usage
//  - req channel: one item is a bitmap word, a base index and a restart flag;
//    only the low WORD_BITS bits of the word are decoded
//  - rsp channel: one item per set bit, lowest bit first, carrying base index
//    plus bit position, the running slot count and a last flag on the
//    highest set bit of the word; a zero word gives no items
//  - restart clears the slot counter before the word is decoded, even for a
//    zero word
//  - the word is stored when the request is taken; the first result is
//    decoded from it into the result register once that register is free
//  - throughput: one result per cycle while the receiver does not stall,
//    from a combinational lowest-bit decode; req_ready stays low until the
//    highest set bit of a word is decoded (a zero word is taken at once)
//  - when the receiver stalls the result register holds and decoding pauses;
//    a new item may be taken while the final result still waits
//  - reset (synchronous) empties the result register, returns the
//    controller to idle and clears the slot counter
`default_nettype none

module bitmap_set_bit_index_decoder
   import bsbid_pkg::*;
#(
   parameter int WORD_BITS  = 64,
   parameter int INDEX_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [WORD_FIELD_BITS-1:0]  req_bitmap_word,
   input  wire logic [INDEX_FIELD_BITS-1:0] req_base_index,
   input  wire logic                        req_restart,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [INDEX_FIELD_BITS-1:0]      rsp_position,
   output logic [SLOT_BITS-1:0]             rsp_slot,
   output logic                             rsp_last
);

   // command and status between the controller and the datapath
   bsbid_cmd_type    dp_cmd;
   bsbid_status_type dp_status;

   // controller: idle / run sequencing and the result valid flag
   bsbid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // datapath: stored word, slot counter, decode and result register
   bsbid_datapath #(
      .WORD_BITS  (WORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .req_bitmap_word (req_bitmap_word),
      .req_base_index  (req_base_index),
      .req_restart     (req_restart),
      .rsp_position    (rsp_position),
      .rsp_slot        (rsp_slot),
      .rsp_last        (rsp_last)
   );

   // a word with set bits keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && dp_status.in_nonzero) |=> !req_ready)
      else $error("decoder took a new item while a word was still being decoded");

   // while a non-last result is taken, the rest of its word is still pending
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |-> !req_ready)
      else $error("decoder went idle before the last result of a word");

   // the datapath is never told to load and decode in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.load && dp_cmd.emit))
      else $error("load and emit commands overlap");

endmodule

`default_nettype wire

// ===== hw/rtl/bsbid_ctrl.sv =====
// bsbid_ctrl: controller state machine of the set-bit index decoder
// depends on bsbid_pkg for the command and status types
`default_nettype none

module bsbid_ctrl
   import bsbid_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  bsbid_status_type      status,
   output bsbid_cmd_type         cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      cmd.load = accept;
      cmd.emit = 1'b0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.in_nonzero) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               if (status.last_bit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bsbid_datapath.sv =====
// bsbid_datapath: word, base and slot counter registers, lowest-set-bit decode
// and the result register; depends on bsbid_pkg
`default_nettype none

module bsbid_datapath
   import bsbid_pkg::*;
#(
   parameter int WORD_BITS  = 64,
   parameter int INDEX_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  bsbid_cmd_type                    cmd,
   output bsbid_status_type                 status,
   input  wire logic [WORD_FIELD_BITS-1:0]  req_bitmap_word,
   input  wire logic [INDEX_FIELD_BITS-1:0] req_base_index,
   input  wire logic                        req_restart,
   output logic [INDEX_FIELD_BITS-1:0]      rsp_position,
   output logic [SLOT_BITS-1:0]             rsp_slot,
   output logic                             rsp_last
);

   localparam int BIT_IDX_BITS = $clog2(WORD_BITS);
   localparam logic [INDEX_FIELD_BITS-1:0] POS_MASK =
      (INDEX_BITS >= INDEX_FIELD_BITS) ? {INDEX_FIELD_BITS{1'b1}}
                                       : ((INDEX_FIELD_BITS'(1) << INDEX_BITS) - 1'b1);

   logic [WORD_BITS-1:0]        word_ff, word_in;
   logic [INDEX_FIELD_BITS-1:0] base_ff;
   logic [SLOT_BITS-1:0]        counter_ff, counter_in;
   logic [INDEX_FIELD_BITS-1:0] position_ff;
   logic [SLOT_BITS-1:0]        slot_ff;
   logic                        last_ff;

   logic [WORD_BITS-1:0]        in_word;
   logic [WORD_BITS-1:0]        low_onehot;
   logic [WORD_BITS-1:0]        word_rest;
   logic [BIT_IDX_BITS-1:0]     bit_idx;
   logic [INDEX_FIELD_BITS-1:0] pos_sum;

   assign in_word = req_bitmap_word[WORD_BITS-1:0];

   // isolate lowest set bit, then encode it with an or per index bit
   assign low_onehot = word_ff & (~word_ff + 1'b1);
   assign word_rest  = word_ff ^ low_onehot;

   always_comb begin
      bit_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_onehot[i]) begin
            bit_idx = bit_idx | BIT_IDX_BITS'(i);
         end
      end
   end

   assign pos_sum = (base_ff + INDEX_FIELD_BITS'(bit_idx)) & POS_MASK;

   assign status.in_nonzero = |in_word;
   assign status.last_bit   = ~|word_rest;

   always_comb begin
      word_in    = word_ff;
      counter_in = counter_ff;
      if (cmd.load) begin
         word_in = in_word;
         if (req_restart) begin
            counter_in = '0;
         end
      end else if (cmd.emit) begin
         word_in    = word_rest;
         counter_in = counter_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else begin
         counter_ff <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (cmd.load) begin
         base_ff <= req_base_index;
      end
      if (cmd.emit) begin
         position_ff <= pos_sum;
         slot_ff     <= counter_ff;
         last_ff     <= status.last_bit;
      end
   end

   assign rsp_position = position_ff;
   assign rsp_slot     = slot_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

// ===== tb/set_bit_index_track_pkg.sv =====
// expected-index tracker for the set-bit index decoder testbench
// builds the index list of each taken word and checks results against it
// depends on bsbid_pkg for the field widths
`timescale 1ns / 100ps

package set_bit_index_track_pkg;
   import bsbid_pkg::*;

   typedef struct {
      logic [INDEX_FIELD_BITS-1:0] position;
      logic [SLOT_BITS-1:0]        slot;
      logic                        last;
   } decoded_index_type;

   class set_bit_index_tracker;
      decoded_index_type     awaited_indices[$];
      logic [SLOT_BITS-1:0]  match_count;
      int                    fault_count;

      function new();
         match_count = '0;
         fault_count = 0;
      endfunction

      // expand one taken word into its indices, lowest bit first
      function void note_word(logic [WORD_FIELD_BITS-1:0] word,
                              logic [INDEX_FIELD_BITS-1:0] base,
                              logic restart);
         decoded_index_type             entry;
         logic [WORD_FIELD_BITS-1:0]    left;
         left = word;
         if (restart) begin
            match_count = '0;
         end
         for (int b = 0; b < WORD_FIELD_BITS; b++) begin
            if (left[b]) begin
               left[b]        = 1'b0;
               entry.position = base + INDEX_FIELD_BITS'(b);
               entry.slot     = match_count;
               entry.last     = (left == '0);
               awaited_indices.insert(awaited_indices.size(), entry);
               match_count    = match_count + 1'b1;
            end
         end
      endfunction

      function void check_index(logic [INDEX_FIELD_BITS-1:0] position,
                                logic [SLOT_BITS-1:0] slot,
                                logic last);
         decoded_index_type want;
         if (awaited_indices.size() == 0) begin
            $error("unexpected index item: position %h slot %h last %b",
                   position, slot, last);
            fault_count++;
            return;
         end
         want = awaited_indices.pop_front();
         if (position !== want.position) begin
            $error("position mismatch: expected %h, actual %h", want.position, position);
            fault_count++;
         end
         if (slot !== want.slot) begin
            $error("slot mismatch: expected %h, actual %h", want.slot, slot);
            fault_count++;
         end
         if (last !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, last);
            fault_count++;
         end
      endfunction

      function int pending();
         return awaited_indices.size();
      endfunction
   endclass

endpackage

// ===== tb/testbench.sv =====
// top-level testbench for bitmap_set_bit_index_decoder
// drives bitmap words with random gaps and stalls, checks every index item
// depends on bsbid_pkg, set_bit_index_track_pkg and the decoder rtl
`timescale 1ns / 100ps

module testbench;
   import bsbid_pkg::*;
   import set_bit_index_track_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_WORDS  = 340;
   localparam int TAIL_CYCLES   = WORD_FIELD_BITS + 16;
   localparam int DIRECTED_WORDS = 12;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [WORD_FIELD_BITS-1:0]   req_bitmap_word = '0;
   logic [INDEX_FIELD_BITS-1:0]  req_base_index = '0;
   logic                         req_restart = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [INDEX_FIELD_BITS-1:0]  rsp_position;
   logic [SLOT_BITS-1:0]         rsp_slot;
   logic                         rsp_last;

   int                           cycle_count = 0;
   set_bit_index_tracker         tracker;

   // directed words: extremes of word and base, position wrap, restart cases
   logic [WORD_FIELD_BITS-1:0]   directed_word[DIRECTED_WORDS] = '{
      64'h0000_0000_0000_0000,   // zero word, nothing out
      64'h0000_0000_0000_0001,   // lowest bit only
      64'h8000_0000_0000_0000,   // highest bit only, position wraps
      64'hFFFF_FFFF_FFFF_FFFF,   // full word with restart
      64'h0000_0000_0000_0000,   // zero word that still clears the counter
      64'h5555_5555_5555_5555,
      64'hAAAA_AAAA_AAAA_AAAA,
      64'hFFFF_FFFF_FFFF_FFFF,   // full word at maximum base, every index past bit 0 wraps
      64'h8000_0000_0000_0001,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0001,
      64'h0000_0001_0000_0000
   };
   logic [INDEX_FIELD_BITS-1:0]  directed_base[DIRECTED_WORDS] = '{
      32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFC1,
      32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF
   };
   logic                         directed_restart[DIRECTED_WORDS] = '{
      1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
   };

   bitmap_set_bit_index_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_bitmap_word (req_bitmap_word),
      .req_base_index  (req_base_index),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_slot        (rsp_slot),
      .rsp_last        (rsp_last)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // receiver: stalls at random with a chance of one in five, except in a calm window
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (cycle_count >= 4000 && cycle_count < 7000) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 20);
      end
   end

   // both handshakes are observed at the edge, before any update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            tracker.note_word(req_bitmap_word, req_base_index, req_restart);
         end
         if (rsp_valid && rsp_ready) begin
            tracker.check_index(rsp_position, rsp_slot, rsp_last);
         end
      end
   end

   // present one word and hold it until the decoder takes it;
   // valid is left high so a back-to-back word needs no second assignment
   task automatic send_word(input logic [WORD_FIELD_BITS-1:0] word,
                            input logic [INDEX_FIELD_BITS-1:0] base,
                            input logic restart,
                            input bit may_idle);
      int gap;
      if (may_idle && $urandom_range(99) < 20) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_bitmap_word <= word;
      req_base_index  <= base;
      req_restart     <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // sender holds off until every awaited index has come back
   task automatic drain_indices();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // mix of densities: mostly sparse words so the run stays short,
   // a share of dense and full words, the odd zero word
   function automatic logic [WORD_FIELD_BITS-1:0] shaped_word();
      int kind;
      kind = $urandom_range(19);
      case (kind)
         0, 1:    return '0;
         2:       return '1;
         3, 4, 5: return WORD_FIELD_BITS'(1) << $urandom_range(WORD_FIELD_BITS - 1);
         6, 7, 8: return {$urandom, $urandom};
         default: return {$urandom, $urandom} & {$urandom, $urandom}
                         & {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [INDEX_FIELD_BITS-1:0] shaped_base();
      if ($urandom_range(9) < 2) begin
         // close to the top so the index sum can wrap
         return 32'hFFFF_FFFF - $urandom_range(WORD_FIELD_BITS - 1);
      end
      return $urandom;
   endfunction

   initial begin
      logic [WORD_FIELD_BITS-1:0]  word;
      logic [INDEX_FIELD_BITS-1:0] base;
      logic                        restart;
      bit                          may_idle;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_WORDS; i++) begin
         send_word(directed_word[i], directed_base[i], directed_restart[i], 1'b1);
      end
      drain_indices();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         word     = shaped_word();
         base     = shaped_base();
         restart  = ($urandom_range(9) == 0);
         // a long run of back-to-back words in the middle
         may_idle = !(i >= 150 && i < 220);
         send_word(word, base, restart, may_idle);
         if (i == 260) begin
            drain_indices();
         end
      end

      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (tracker.fault_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("testbench: errors");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/bsbid_pkg.sv
hw/rtl/bsbid_ctrl.sv
hw/rtl/bsbid_datapath.sv
hw/rtl/bitmap_set_bit_index_decoder.sv
tb/set_bit_index_track_pkg.sv
tb/testbench.sv
